FILE: rtl/chs_pkg.sv
// Package for the CHS geometry search: widths, search limits, trial table and sequencer states.
`default_nettype none
package chs_pkg;

  localparam int unsigned SECTOR_SHIFT  = 9;                   // 512-byte sectors
  localparam int unsigned BYTES_W       = 32;
  localparam int unsigned TOTAL_W       = BYTES_W - SECTOR_SHIFT;
  localparam int unsigned DIV_W         = 9;                   // divisor up to 256
  localparam int unsigned CNT_W         = $clog2(TOTAL_W);
  localparam int unsigned CYL_W         = 11;
  localparam int unsigned HEADS_W       = 9;
  localparam int unsigned SPT_W         = 6;
  localparam int unsigned MAX_CYLINDERS = 1024;

  localparam logic [HEADS_W-1:0] HEADS_FIRST = 9'd2;
  localparam logic [HEADS_W-1:0] HEADS_LAST  = 9'd256;
  localparam logic [HEADS_W-1:0] HEADS_STEP  = 9'd2;

  localparam int unsigned PREF_COUNT = 5;
  localparam int unsigned SPT_FIRST  = 16;
  localparam int unsigned SPT_LAST   = 63;
  localparam int unsigned TRIAL_W    = 6;
  localparam logic [TRIAL_W-1:0] TRIAL_LAST = TRIAL_W'(PREF_COUNT + SPT_LAST - SPT_FIRST);

  localparam logic [SPT_W-1:0] PREF_SPT [PREF_COUNT] = '{6'd63, 6'd17, 6'd34, 6'd54, 6'd26};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD_DIV,
    ST_SPT_DIV,
    ST_DONE
  } state_t;

  // Map a trial index to its sectors-per-track value: preferred list, then the full range.
  function automatic logic [SPT_W-1:0] spt_of(input logic [TRIAL_W-1:0] idx);
    logic [SPT_W-1:0] val;
    if (idx < TRIAL_W'(PREF_COUNT)) begin
      val = PREF_SPT[idx[2:0]];
    end else begin
      val = SPT_W'(idx - TRIAL_W'(PREF_COUNT) + TRIAL_W'(SPT_FIRST));
    end
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/chs_geometry_search_core.sv
// CHS geometry search: sequencer around one shared bit-serial restoring divider.
//
// Usage: present a disk image size on image_bytes with in_valid; the beat is
// taken when in_valid and in_ready are both high. in_ready is high only while
// the block is idle, so one search runs at a time. The result beat (found,
// cylinders, heads, sectors_per_track) is shown with out_valid and held until
// out_ready takes it; the block then returns to idle and raises in_ready.
//
// Search: a size that is not a whole number of 512-byte sectors gives a
// failing result in the next cycle after acceptance. Otherwise every trial
// is one division of a 23-bit value on the shared divider, with the next
// division loaded in the last cycle of the previous one. A search runs one
// division per head count tried plus one per sectors-per-track trial for a
// head count that divides the sector count; the worst case is every one of
// 128 head counts dividing and all 53 trials failing.
//
// Reset: rst returns the sequencer to idle and drops any result. A stalled
// receiver simply holds the block in the result state with outputs steady.
`default_nettype none
module chs_geometry_search_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [chs_pkg::BYTES_W-1:0]   image_bytes,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic [chs_pkg::CYL_W-1:0]          cylinders,
  output logic [chs_pkg::HEADS_W-1:0]        heads,
  output logic [chs_pkg::SPT_W-1:0]          sectors_per_track
);

  chs_pkg::state_t state, state_next;

  // Search registers
  logic [chs_pkg::TOTAL_W-1:0] total, total_next;       // sector count
  logic [chs_pkg::TOTAL_W-1:0] per_head, per_head_next; // sectors per head
  logic [chs_pkg::HEADS_W-1:0] head, head_next;
  logic [chs_pkg::TRIAL_W-1:0] trial, trial_next;

  // Shared divider registers
  logic [chs_pkg::TOTAL_W-1:0] quo, quo_next;   // dividend shifting out, quotient shifting in
  logic [chs_pkg::DIV_W-1:0]   rem, rem_next;
  logic [chs_pkg::DIV_W-1:0]   dvsr, dvsr_next;
  logic [chs_pkg::CNT_W-1:0]   cnt, cnt_next;

  // Result registers
  logic                        found_next;
  logic [chs_pkg::CYL_W-1:0]   cylinders_next;
  logic [chs_pkg::HEADS_W-1:0] heads_next;
  logic [chs_pkg::SPT_W-1:0]   spt_next;

  // One restoring divider step
  logic [chs_pkg::DIV_W:0]     rem_sh;
  logic                        ge;
  logic [chs_pkg::DIV_W-1:0]   rem_step;
  logic [chs_pkg::TOTAL_W-1:0] quo_step;
  logic                        last;
  logic [chs_pkg::TRIAL_W-1:0] trial_inc;

  assign rem_sh    = {rem, quo[chs_pkg::TOTAL_W-1]};
  assign ge        = rem_sh >= {1'b0, dvsr};
  assign rem_step  = ge ? chs_pkg::DIV_W'(rem_sh - {1'b0, dvsr}) : chs_pkg::DIV_W'(rem_sh);
  assign quo_step  = {quo[chs_pkg::TOTAL_W-2:0], ge};
  assign last      = cnt == chs_pkg::CNT_W'(chs_pkg::TOTAL_W - 1);
  assign trial_inc = trial + chs_pkg::TRIAL_W'(1);

  assign in_ready  = state == chs_pkg::ST_IDLE;
  assign out_valid = state == chs_pkg::ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    total             <= total_next;
    per_head          <= per_head_next;
    head              <= head_next;
    trial             <= trial_next;
    quo               <= quo_next;
    rem               <= rem_next;
    dvsr              <= dvsr_next;
    cnt               <= cnt_next;
    found             <= found_next;
    cylinders         <= cylinders_next;
    heads             <= heads_next;
    sectors_per_track <= spt_next;
  end

  always_comb begin
    state_next     = state;
    total_next     = total;
    per_head_next  = per_head;
    head_next      = head;
    trial_next     = trial;
    quo_next       = quo;
    rem_next       = rem;
    dvsr_next      = dvsr;
    cnt_next       = cnt;
    found_next     = found;
    cylinders_next = cylinders;
    heads_next     = heads;
    spt_next       = sectors_per_track;

    case (state)
      chs_pkg::ST_IDLE: begin
        if (in_valid) begin
          found_next     = 1'b0;
          cylinders_next = '0;
          heads_next     = '0;
          spt_next       = '0;
          if (image_bytes[chs_pkg::SECTOR_SHIFT-1:0] != '0) begin
            // Partial sector: fail at once
            state_next = chs_pkg::ST_DONE;
          end else begin
            total_next = image_bytes[chs_pkg::BYTES_W-1:chs_pkg::SECTOR_SHIFT];
            head_next  = chs_pkg::HEADS_FIRST;
            quo_next   = image_bytes[chs_pkg::BYTES_W-1:chs_pkg::SECTOR_SHIFT];
            rem_next   = '0;
            dvsr_next  = chs_pkg::HEADS_FIRST;
            cnt_next   = '0;
            state_next = chs_pkg::ST_HEAD_DIV;
          end
        end
      end

      chs_pkg::ST_HEAD_DIV, chs_pkg::ST_SPT_DIV: begin
        quo_next = quo_step;
        rem_next = rem_step;
        cnt_next = cnt + chs_pkg::CNT_W'(1);
        if (last) begin
          cnt_next = '0;
          rem_next = '0;
          if (state == chs_pkg::ST_HEAD_DIV && rem_step == '0) begin
            // Head count divides: start the sectors-per-track trials
            per_head_next = quo_step;
            trial_next    = '0;
            quo_next      = quo_step;
            dvsr_next     = chs_pkg::DIV_W'(chs_pkg::spt_of('0));
            state_next    = chs_pkg::ST_SPT_DIV;
          end else if (state == chs_pkg::ST_SPT_DIV && rem_step == '0 &&
                       quo_step <= chs_pkg::TOTAL_W'(chs_pkg::MAX_CYLINDERS)) begin
            found_next     = 1'b1;
            cylinders_next = quo_step[chs_pkg::CYL_W-1:0];
            heads_next     = head;
            spt_next       = chs_pkg::spt_of(trial);
            state_next     = chs_pkg::ST_DONE;
          end else if (state == chs_pkg::ST_SPT_DIV && trial != chs_pkg::TRIAL_LAST) begin
            trial_next = trial_inc;
            quo_next   = per_head;
            dvsr_next  = chs_pkg::DIV_W'(chs_pkg::spt_of(trial_inc));
          end else if (head == chs_pkg::HEADS_LAST) begin
            // Every head count tried: fail
            state_next = chs_pkg::ST_DONE;
          end else begin
            head_next  = head + chs_pkg::HEADS_STEP;
            quo_next   = total;
            dvsr_next  = head + chs_pkg::HEADS_STEP;
            state_next = chs_pkg::ST_HEAD_DIV;
          end
        end
      end

      chs_pkg::ST_DONE: begin
        if (out_ready) begin
          state_next = chs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = chs_pkg::ST_IDLE;
      end
    endcase
  end

  // Never accept and present at the same time
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // A partial-sector size fails in the next cycle
  a_partial_fail: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && image_bytes[chs_pkg::SECTOR_SHIFT-1:0] != '0)
      |=> (out_valid && !found))
    else $error("partial sector size did not fail at once");

  // A found geometry is well formed
  a_found_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (heads != '0 && !heads[0] &&
      sectors_per_track >= chs_pkg::SPT_W'(chs_pkg::SPT_FIRST) &&
      cylinders <= chs_pkg::CYL_W'(chs_pkg::MAX_CYLINDERS)))
    else $error("found geometry out of range");

  // A failed search reports zero geometry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (cylinders == '0 && heads == '0 && sectors_per_track == '0))
    else $error("failed search with nonzero geometry");

  // The divider remainder stays below its divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == chs_pkg::ST_HEAD_DIV || state == chs_pkg::ST_SPT_DIV) |-> (rem < dvsr))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: tb/chs_geometry_search_core_tb.sv
// Self-checking testbench for the CHS geometry search core, with a behavioral predictor.
`default_nettype none
module chs_geometry_search_core_tb;

  // One result beat, packed in port order.
  typedef struct packed {
    logic                        found;
    logic [chs_pkg::CYL_W-1:0]   cylinders;
    logic [chs_pkg::HEADS_W-1:0] heads;
    logic [chs_pkg::SPT_W-1:0]   spt;
  } geometry_t;

  // One image size to offer, with an optional hand-typed answer.
  typedef struct {
    logic [chs_pkg::BYTES_W-1:0] bytes;
    bit                          known;
    geometry_t                   value;
  } image_row_t;

  localparam int unsigned RANDOM_PER_PHASE = 27;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned TAIL_CYCLES      = 50;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam geometry_t   NO_GEOMETRY      = '0;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [chs_pkg::BYTES_W-1:0] image_bytes = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        found;
  logic [chs_pkg::CYL_W-1:0]   cylinders;
  logic [chs_pkg::HEADS_W-1:0] heads;
  logic [chs_pkg::SPT_W-1:0]   sectors_per_track;

  chs_geometry_search_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .image_bytes      (image_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .cylinders        (cylinders),
    .heads            (heads),
    .sectors_per_track(sectors_per_track)
  );

  // 12-unit clock: low half first, then high half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pacing knobs, owned by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_tokens   = 0;

  // Receiver-side bookkeeping.
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  // Answers waiting for their result beat, oldest first, and the per-beat hints
  // that say whether a directed row carries its own typed answer.
  geometry_t  pending_geometry [$];
  image_row_t image_hints [$];
  image_row_t beat_hint;
  geometry_t  want_geometry;
  geometry_t  got_geometry;

  int unsigned images_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned geometries_found = 0;
  int unsigned error_count     = 0;

  // Sectors-per-track values that the search prefers, in trial order.
  function automatic int unsigned preferred_spt(input int unsigned idx);
    case (idx)
      0: return 63;
      1: return 17;
      2: return 34;
      3: return 54;
      default: return 26;
    endcase
  endfunction

  // Compute the geometry the core should report for one image size: walk even
  // head counts upward, and for each head count that divides the sector total
  // try the preferred track lengths, then the full range, taking the first
  // one that divides evenly and stays within the cylinder limit.
  function automatic geometry_t search_geometry(input logic [chs_pkg::BYTES_W-1:0] bytes);
    geometry_t   g;
    int unsigned total;
    int unsigned per_head;
    int unsigned h;
    int unsigned k;
    int unsigned spt;
    bit          ok;
    g  = NO_GEOMETRY;
    ok = 1'b0;
    if (bytes[chs_pkg::SECTOR_SHIFT-1:0] == '0) begin
      total = bytes >> chs_pkg::SECTOR_SHIFT;
      for (h = chs_pkg::HEADS_FIRST; h <= chs_pkg::HEADS_LAST && !ok;
           h += chs_pkg::HEADS_STEP) begin
        if (total % h == 0) begin
          per_head = total / h;
          for (k = 0; k <= chs_pkg::PREF_COUNT + chs_pkg::SPT_LAST - chs_pkg::SPT_FIRST && !ok;
               k++) begin
            spt = (k < chs_pkg::PREF_COUNT) ? preferred_spt(k)
                                            : k - chs_pkg::PREF_COUNT + chs_pkg::SPT_FIRST;
            if (per_head % spt == 0 && per_head / spt <= chs_pkg::MAX_CYLINDERS) begin
              ok          = 1'b1;
              g.found     = 1'b1;
              g.cylinders = chs_pkg::CYL_W'(per_head / spt);
              g.heads     = chs_pkg::HEADS_W'(h);
              g.spt       = chs_pkg::SPT_W'(spt);
            end
          end
        end
      end
    end
    return g;
  endfunction

  // Draw one random image size. Most are built from a real geometry so the
  // search runs deep; the rest are raw noise, small sector totals and a few
  // sizes near the top of the range, which are the slow ones.
  function automatic logic [chs_pkg::BYTES_W-1:0] random_image();
    int unsigned pick;
    int unsigned h;
    int unsigned spt;
    int unsigned total;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return $urandom();
    end else if (pick < 80) begin
      h     = 2 * $urandom_range(16, 1);
      spt   = ($urandom_range(1) != 0) ? preferred_spt($urandom_range(4))
                                       : $urandom_range(chs_pkg::SPT_LAST, chs_pkg::SPT_FIRST);
      total = h * spt * $urandom_range(chs_pkg::MAX_CYLINDERS, 0);
    end else if (pick < 94) begin
      total = $urandom_range(200000);
    end else if (pick < 97) begin
      total = 256 * $urandom_range(32, chs_pkg::SPT_FIRST) *
              $urandom_range(chs_pkg::MAX_CYLINDERS - 1, 1);
    end else begin
      total = $urandom_range((1 << chs_pkg::TOTAL_W) - 1);
    end
    return chs_pkg::BYTES_W'(total) << chs_pkg::SECTOR_SHIFT;
  endfunction

  // Offer one beat. Idle first at the current sender rate, then raise valid
  // and hold it with the payload steady until the core takes it.
  task automatic push_image(input image_row_t row);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    image_hints.push_back(row);
    in_valid    <= 1'b1;
    image_bytes <= row.bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    images_sent++;
  endtask

  // Build a directed row; pass known = 0 to leave the answer to the predictor.
  function automatic image_row_t row_of(input logic [chs_pkg::BYTES_W-1:0] bytes,
                                        input bit known, input geometry_t value);
    image_row_t r;
    r.bytes = bytes;
    r.known = known;
    r.value = value;
    return r;
  endfunction

  // Drive out_ready at the falling edge. A hold request waits for a result
  // beat, then drops ready for a long counted stretch so the core sits on
  // its result and blocks new input.
  always @(negedge clk) begin
    if (hold_served != hold_tokens && out_valid) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample both channels at the rising edge. Queue the answer for every input
  // beat; match every result beat against the oldest answer.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (image_hints.size() != 0) begin
          beat_hint = image_hints.pop_front();
        end else begin
          beat_hint = row_of(image_bytes, 1'b0, NO_GEOMETRY);
        end
        pending_geometry.push_back(beat_hint.known ? beat_hint.value
                                                   : search_geometry(image_bytes));
      end
      if (out_valid && out_ready) begin
        got_geometry = {found, cylinders, heads, sectors_per_track};
        results_checked++;
        if (got_geometry.found) geometries_found++;
        if (pending_geometry.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("unexpected result beat: found=%0b cyl=%0d heads=%0d spt=%0d",
                     found, cylinders, heads, sectors_per_track);
          end
        end else begin
          want_geometry = pending_geometry.pop_front();
          if (got_geometry !== want_geometry) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("bad result %0d: want found=%0b cyl=%0d heads=%0d spt=%0d",
                       results_checked, want_geometry.found, want_geometry.cylinders,
                       want_geometry.heads, want_geometry.spt);
              $display("               got  found=%0b cyl=%0d heads=%0d spt=%0d",
                       found, cylinders, heads, sectors_per_track);
            end
          end
        end
      end
    end
  end

  // Stimulus: directed rows, then three paced random phases.
  initial begin
    image_row_t directed_rows [$];
    geometry_t  zero_size;
    zero_size = '{found: 1'b1, cylinders: '0, heads: chs_pkg::HEADS_FIRST,
                  spt: chs_pkg::SPT_W'(63)};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero bytes: an empty total passes the very first trial.
    directed_rows.push_back(row_of(32'd0, 1'b1, zero_size));
    // Sizes that are not whole sectors, including the all-ones extreme.
    directed_rows.push_back(row_of(32'd1, 1'b1, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd256, 1'b1, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd511, 1'b1, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd513, 1'b1, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'hFFFF_FFFF, 1'b1, NO_GEOMETRY));
    // Odd sector totals: no even head count divides them.
    directed_rows.push_back(row_of(32'd512, 1'b1, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'hFFFF_FE00, 1'b1, NO_GEOMETRY));
    // Plain two-head hits on the first two preferred track lengths.
    directed_rows.push_back(row_of(32'd645120, 1'b1,
                                   '{found: 1'b1, cylinders: 11'd10, heads: 9'd2, spt: 6'd63}));
    directed_rows.push_back(row_of(32'd87040, 1'b1,
                                   '{found: 1'b1, cylinders: 11'd5, heads: 9'd2, spt: 6'd17}));
    // Two sectors only: heads divide but no track length does.
    directed_rows.push_back(row_of(32'd1024, 1'b0, NO_GEOMETRY));
    // Later preferred lengths, the full-range fallback, the cylinder limit.
    directed_rows.push_back(row_of(32'd34816000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd55296000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd26624000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd19456000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd66060288, 1'b0, NO_GEOMETRY));
    // Large totals that push the head count up.
    directed_rows.push_back(row_of(32'h8000_0000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd4096000000, 1'b0, NO_GEOMETRY));
    directed_rows.push_back(row_of(32'd4290772992, 1'b0, NO_GEOMETRY));
    // Twice a large prime: only two heads divide, and nothing fits.
    directed_rows.push_back(row_of(32'd4294964224, 1'b0, NO_GEOMETRY));

    // Slow receiver, moderately busy sender.
    send_idle_pct = 28;
    recv_idle_pct = 76;
    foreach (directed_rows[i]) push_image(directed_rows[i]);
    repeat (RANDOM_PER_PHASE) push_image(row_of(random_image(), 1'b0, NO_GEOMETRY));

    // Swap the pacing: sparse sender, eager receiver.
    send_idle_pct = 76;
    recv_idle_pct = 28;
    repeat (RANDOM_PER_PHASE) push_image(row_of(random_image(), 1'b0, NO_GEOMETRY));

    // Full rate, opened by a long receiver hold while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_tokens   = hold_tokens + 1;
    repeat (RANDOM_PER_PHASE) push_image(row_of(random_image(), 1'b0, NO_GEOMETRY));

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain every answer, then idle a little longer for any stray beat.
    while (pending_geometry.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("searched %0d image sizes (%0d directed), %0d geometries found, %0d rejected",
             images_sent, directed_rows.size(), geometries_found,
             results_checked - geometries_found);
    $display("pacing: slow receiver, slow sender, full rate with a %0d-cycle receiver hold",
             HOLD_CYCLES);
    if (error_count == 0 && pending_geometry.size() == 0) begin
      $display("chs_geometry_search_core: match");
    end else begin
      $display("%0d bad result beats", error_count);
      $display("chs_geometry_search_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, every search at its worst.
  initial begin
    #1000000000;
    $display("timeout with %0d results outstanding", pending_geometry.size());
    $display("chs_geometry_search_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
